@@ src/sbsd_pkg.sv @@
// Package for the stack bytecode stream decoder.
// Holds execution class codes, status codes and shared constants; no dependencies.
`default_nettype none
package sbsd_pkg;

  localparam int unsigned MaxMethodBytes = 65536;
  localparam int unsigned PosW = (MaxMethodBytes > 65536) ? 17 : 16;

  typedef enum logic [5:0] {
    CLS_PUSH_RECV_VAR, CLS_PUSH_LIT_VAR, CLS_PUSH_LIT_CONST, CLS_PUSH_TEMP,
    CLS_PUSH_RECEIVER, CLS_PUSH_TRUE, CLS_PUSH_FALSE, CLS_PUSH_NIL,
    CLS_PUSH_ZERO, CLS_PUSH_ONE, CLS_DUP,
    CLS_RET_RECEIVER, CLS_RET_TRUE, CLS_RET_FALSE, CLS_RET_NIL, CLS_RET_TOP,
    CLS_POP, CLS_ADD, CLS_SUB, CLS_LESS, CLS_GREATER, CLS_EQUAL,
    CLS_NOT_EQUAL, CLS_MUL, CLS_SEND, CLS_JUMP, CLS_JUMP_TRUE,
    CLS_JUMP_FALSE, CLS_POP_STORE_RECV, CLS_POP_STORE_TEMP, CLS_NOP,
    CLS_PUSH_INTEGER, CLS_POP_STORE_LIT, CLS_STORE_RECV, CLS_STORE_TEMP
  } class_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  localparam logic [7:0] OP_EXT_A = 8'hE0;
  localparam logic [7:0] OP_EXT_B = 8'hE1;
  localparam logic [7:0] OP_EXT_NOP = 8'hF8;

  // Instruction length from the first byte; zero marks an unsupported opcode.
  function automatic logic [1:0] need_len(input logic [7:0] op);
    logic [1:0] len;
    if (op == 8'h52 || (op >= 8'h54 && op <= 8'h57) || (op >= 8'h5D && op <= 8'h5F) ||
        (op >= 8'hD9 && op <= 8'hDF)) len = 2'd0;
    else if (op < 8'hE0) len = 2'd1;
    else if (op == 8'hE6 || op == 8'hE7 || op == 8'hEB || op == 8'hEC || op == 8'hF4 ||
             op == 8'hF6 || op == 8'hF7 || op >= 8'hF9) len = 2'd0;
    else if (op == OP_EXT_NOP) len = 2'd3;
    else len = 2'd2;
    return len;
  endfunction

endpackage
`default_nettype wire

@@ src/stack_bytecode_stream_decoder.sv @@
// Stack bytecode stream decoder: one bytecode byte per request in, one decoded
// instruction per completed instruction out. Depends on sbsd_pkg.
// A result is registered when its completing byte is accepted. One byte per cycle
// unless a held result is not taken; the register refills in the cycle it is taken.
// Reset (rst_n low, synchronous) clears the decode state and the output valid.
`default_nettype none
module stack_bytecode_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       out_class_code,
  output logic [7:0]       out_opcode,
  output logic signed [31:0] out_operand,
  output logic signed [8:0]  out_second_operand,
  output logic signed [31:0] out_branch_target,
  output logic [15:0]      out_byte_offset,
  output logic [1:0]       out_byte_length,
  output logic [1:0]       out_status,
  output logic             out_end_of_method
);

  localparam int unsigned PW = sbsd_pkg::PosW;

  logic [PW-1:0] pos_r, pos_nxt, start_r, start_nxt;
  logic [7:0]  pend_op_r, pend_op_nxt, first_r, first_nxt;
  logic [1:0]  pend_cnt_r, pend_cnt_nxt;
  logic [31:0] ext_a_r, ext_a_nxt, ext_b_r, ext_b_nxt;
  logic        drop_r, drop_nxt;

  logic        out_valid_r;
  logic [5:0]  cls_r;
  logic [7:0]  opc_r;
  logic [31:0] opnd_r, tgt_r;
  logic [8:0]  opnd2_r;
  logic [15:0] off_r;
  logic [1:0]  len_r, st_r;
  logic        eom_r;

  logic        fire, emit;
  logic [5:0]  cls;
  logic [7:0]  opc;
  logic [31:0] opnd, tgt;
  logic [8:0]  opnd2;
  logic [1:0]  len, st;
  logic [PW-1:0] cur_start;

  assign in_ready = !out_valid_r || out_ready;
  assign fire = in_valid && in_ready;

  always_comb begin
    logic [1:0]  nl;
    logic [7:0]  op, b;
    logic [31:0] a_ext, b_ext, start32;
    logic [PW:0] inc;
    pos_nxt = pos_r; start_nxt = start_r; pend_op_nxt = pend_op_r; first_nxt = first_r;
    pend_cnt_nxt = pend_cnt_r; ext_a_nxt = ext_a_r; ext_b_nxt = ext_b_r; drop_nxt = drop_r;
    emit = 1'b0;
    b = in_byte_value;
    nl = sbsd_pkg::need_len(b);
    op = (pend_cnt_r == 2'd0) ? b : pend_op_r;
    cur_start = (pend_cnt_r == 2'd0) ? pos_r : start_r;
    start32 = 32'(cur_start);
    a_ext = {ext_a_r[23:0], b};
    b_ext = {ext_b_r[23:0], b};
    cls = sbsd_pkg::CLS_PUSH_RECV_VAR; opc = op; opnd = '1; opnd2 = '1; tgt = '1;
    len = 2'd1; st = sbsd_pkg::ST_OK;
    inc = {1'b0, pos_r} + 1'b1;
    if (drop_r) begin
      emit = 1'b0;
    end else if (pend_cnt_r == 2'd0) begin
      start_nxt = pos_r;
      emit = 1'b1;
      if (nl == 2'd0) begin
        st = sbsd_pkg::ST_UNSUPPORTED;
        drop_nxt = 1'b1;
      end else if (nl == 2'd1) begin
        ext_a_nxt = '0; ext_b_nxt = '0;
        priority if (b <= 8'h0F) begin
          cls = sbsd_pkg::CLS_PUSH_RECV_VAR; opnd = 32'(b[3:0]);
        end else if (b <= 8'h1F) begin
          cls = sbsd_pkg::CLS_PUSH_LIT_VAR; opnd = 32'(b[3:0]);
        end else if (b <= 8'h3F) begin
          cls = sbsd_pkg::CLS_PUSH_LIT_CONST; opnd = 32'(b[4:0]);
        end else if (b <= 8'h4B) begin
          cls = sbsd_pkg::CLS_PUSH_TEMP; opnd = 32'(b - 8'h40);
        end else if (b <= 8'h51) begin
          cls = 6'(sbsd_pkg::CLS_PUSH_RECEIVER) + 6'(b - 8'h4C);
        end else if (b == 8'h53) begin
          cls = sbsd_pkg::CLS_DUP;
        end else if (b >= 8'h58 && b <= 8'h5C) begin
          cls = 6'(sbsd_pkg::CLS_RET_RECEIVER) + 6'(b - 8'h58);
        end else if (b >= 8'h60 && b <= 8'h6F) begin
          opnd = 32'(b[3:0]);
          unique case (b[3:0])
            4'h0: cls = sbsd_pkg::CLS_ADD;
            4'h1: cls = sbsd_pkg::CLS_SUB;
            4'h2: cls = sbsd_pkg::CLS_LESS;
            4'h3: cls = sbsd_pkg::CLS_GREATER;
            4'h6: cls = sbsd_pkg::CLS_EQUAL;
            4'h7: cls = sbsd_pkg::CLS_NOT_EQUAL;
            4'h8: cls = sbsd_pkg::CLS_MUL;
            default: cls = sbsd_pkg::CLS_SEND;
          endcase
        end else if (b >= 8'h70 && b <= 8'h7F) begin
          cls = sbsd_pkg::CLS_SEND; opnd = 32'(b[3:0]); opnd2 = 9'd1;
        end else if (b >= 8'h80 && b <= 8'hAF) begin
          cls = sbsd_pkg::CLS_SEND; opnd = 32'(b[3:0]); opnd2 = 9'(b[5:4]);
        end else if (b >= 8'hB0 && b <= 8'hC7) begin
          cls = 6'(sbsd_pkg::CLS_JUMP) + 6'((b - 8'hB0) >> 3);
          tgt = start32 + 32'd2 + 32'(b[2:0]);
        end else if (b >= 8'hC8 && b <= 8'hCF) begin
          cls = sbsd_pkg::CLS_POP_STORE_RECV; opnd = 32'(b[2:0]);
        end else if (b >= 8'hD0 && b <= 8'hD7) begin
          cls = sbsd_pkg::CLS_POP_STORE_TEMP; opnd = 32'(b[2:0]);
        end else begin
          cls = sbsd_pkg::CLS_POP;
        end
      end else begin
        pend_op_nxt = b;
        pend_cnt_nxt = nl - 2'd1;
        emit = in_last_byte;
        st = sbsd_pkg::ST_TRUNCATED;
      end
    end else if (pend_cnt_r == 2'd2) begin
      first_nxt = b;
      pend_cnt_nxt = 2'd1;
      emit = in_last_byte;
      st = sbsd_pkg::ST_TRUNCATED;
      len = 2'd2;
    end else begin
      pend_cnt_nxt = 2'd0;
      emit = 1'b1;
      if (pend_op_r == sbsd_pkg::OP_EXT_NOP) begin
        len = 2'd3; cls = sbsd_pkg::CLS_NOP;
        ext_a_nxt = '0; ext_b_nxt = '0;
      end else begin
        len = 2'd2;
        ext_a_nxt = '0; ext_b_nxt = '0;
        unique case (pend_op_r)
          sbsd_pkg::OP_EXT_A: begin
            cls = sbsd_pkg::CLS_NOP; ext_a_nxt = a_ext; ext_b_nxt = ext_b_r;
          end
          sbsd_pkg::OP_EXT_B: begin
            cls = sbsd_pkg::CLS_NOP; ext_a_nxt = ext_a_r;
            ext_b_nxt = b[7] ? (b_ext | 32'hFFFFFF00) : b_ext;
          end
          8'hE2: begin cls = sbsd_pkg::CLS_PUSH_RECV_VAR; opnd = a_ext; end
          8'hE3: begin cls = sbsd_pkg::CLS_PUSH_LIT_VAR; opnd = a_ext; end
          8'hE4: begin cls = sbsd_pkg::CLS_PUSH_LIT_CONST; opnd = a_ext; end
          8'hE5: begin cls = sbsd_pkg::CLS_PUSH_TEMP; opnd = 32'(b); end
          8'hE8: begin cls = sbsd_pkg::CLS_PUSH_INTEGER; opnd = {b_ext[28:0], 3'b001}; end
          8'hE9: begin cls = sbsd_pkg::CLS_PUSH_INTEGER; opnd = {b_ext[28:0], 3'b011}; end
          8'hEA: begin
            cls = sbsd_pkg::CLS_SEND;
            opnd = 32'({ext_a_r[10:0], b[7:3]});
            opnd2 = 9'({ext_b_r[4:0], b[2:0]});
          end
          8'hED, 8'hEE, 8'hEF: begin
            cls = 6'(sbsd_pkg::CLS_JUMP) + 6'(pend_op_r - 8'hED);
            opc = 8'hB0 + {3'(pend_op_r - 8'hED), 3'b000};
            tgt = start32 + 32'd2 + b_ext;
          end
          8'hF0: begin cls = sbsd_pkg::CLS_POP_STORE_RECV; opc = 8'hC8; opnd = a_ext; end
          8'hF1: begin cls = sbsd_pkg::CLS_POP_STORE_LIT; opnd = a_ext; end
          8'hF2: begin cls = sbsd_pkg::CLS_POP_STORE_TEMP; opc = 8'hD0; opnd = 32'(b); end
          8'hF3: begin cls = sbsd_pkg::CLS_STORE_RECV; opnd = a_ext; end
          default: begin cls = sbsd_pkg::CLS_STORE_TEMP; opnd = 32'(b); end
        endcase
      end
    end
    if (st != sbsd_pkg::ST_OK) begin
      cls = sbsd_pkg::CLS_PUSH_RECV_VAR; opnd = '1; opnd2 = '1; tgt = '1;
    end
    if (in_last_byte) begin
      pos_nxt = '0; start_nxt = '0; pend_op_nxt = '0; pend_cnt_nxt = '0; first_nxt = '0;
      ext_a_nxt = '0; ext_b_nxt = '0; drop_nxt = 1'b0;
    end else begin
      pos_nxt = (inc >= (PW+1)'(sbsd_pkg::MaxMethodBytes)) ? '0 : inc[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; start_r <= '0; pend_op_r <= '0; first_r <= '0; pend_cnt_r <= '0;
      ext_a_r <= '0; ext_b_r <= '0; drop_r <= 1'b0; out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        pos_r <= pos_nxt; start_r <= start_nxt; pend_op_r <= pend_op_nxt;
        first_r <= first_nxt; pend_cnt_r <= pend_cnt_nxt;
        ext_a_r <= ext_a_nxt; ext_b_r <= ext_b_nxt; drop_r <= drop_nxt;
      end
      if (fire) out_valid_r <= emit;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      cls_r <= cls; opc_r <= opc; opnd_r <= opnd; opnd2_r <= opnd2; tgt_r <= tgt;
      off_r <= 16'(cur_start); len_r <= len; st_r <= st; eom_r <= in_last_byte;
    end
  end

  assign out_valid = out_valid_r;
  assign out_class_code = cls_r;
  assign out_opcode = opc_r;
  assign out_operand = opnd_r;
  assign out_second_operand = opnd2_r;
  assign out_branch_target = tgt_r;
  assign out_byte_offset = off_r;
  assign out_byte_length = len_r;
  assign out_status = st_r;
  assign out_end_of_method = eom_r;

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_last_byte) |=> (pend_cnt_r == 2'd0 && !drop_r && pos_r == '0))
    else $error("state not cleared after last byte");
  a_err_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && emit && st == sbsd_pkg::ST_UNSUPPORTED && !in_last_byte) |=> drop_r)
    else $error("unsupported opcode did not start dropping");
  a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && drop_r) |=> !out_valid_r)
    else $error("result while dropping");
  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_cnt_r != 2'd3)
    else $error("bad pending count");

endmodule
`default_nettype wire
